/* hdl/delta_queue_timer_engine_unit_assert.svh */
// Assertion macros for the delta queue timer engine
`ifndef DELTA_QUEUE_TIMER_ENGINE_UNIT_ASSERT_SVH
`define DELTA_QUEUE_TIMER_ENGINE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define DQTE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define DQTE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/dqte_pkg.sv */
// Shared types, codes and constants of the delta queue timer engine
package dqte_pkg;

   localparam int SLOT_COUNT_DEF = 16;
   localparam int DELAY_BITS_DEF = 24;
   localparam int MAX_RUN        = 16;
   localparam int RUN_W          = $clog2(MAX_RUN);
   localparam int SLOT_FIELD_W   = 4;
   localparam int DELAY_FIELD_W  = 24;
   localparam int TAG_W          = 16;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_EXPIRY = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_NOTACT = 2'd2;

   localparam logic [1:0] PKT_NONE   = 2'd0;
   localparam logic [1:0] PKT_SEARCH = 2'd1;
   localparam logic [1:0] PKT_PUSH   = 2'd2;
   localparam logic [1:0] PKT_HOLE   = 2'd3;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [DELAY_FIELD_W-1:0] delay_ticks;
      logic [SLOT_FIELD_W-1:0]  target_slot;
      logic [TAG_W-1:0]         user_tag;
   } dqte_req_type;

   typedef struct packed {
      logic [1:0]              result_kind;
      logic [SLOT_FIELD_W-1:0] result_slot;
      logic [TAG_W-1:0]        result_tag;
      logic [1:0]              status;
      logic                    last_of_run;
   } dqte_rsp_type;

   typedef struct packed {
      logic                    shift_all;
      logic                    cancel;
      logic [SLOT_FIELD_W-1:0] target;
   } dqte_ctl_type;

endpackage

/* hdl/dqte_cell.sv */
// One list position of the delta queue, with its travelling packet
module dqte_cell
   import dqte_pkg::*;
#(
   parameter int SLOT_W     = 4,
   parameter int DELAY_BITS = DELAY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dqte_ctl_type          ctl,
   input  logic                  dec_head,
   input  logic [1:0]            pin_kind,
   input  logic [SLOT_W-1:0]     pin_slot,
   input  logic [DELAY_BITS-1:0] pin_delta,
   input  logic [TAG_W-1:0]      pin_tag,
   input  logic                  nxt_valid,
   input  logic [SLOT_W-1:0]     nxt_slot,
   input  logic [DELAY_BITS-1:0] nxt_delta,
   input  logic [TAG_W-1:0]      nxt_tag,
   output logic                  e_valid,
   output logic [SLOT_W-1:0]     e_slot,
   output logic [DELAY_BITS-1:0] e_delta,
   output logic [TAG_W-1:0]      e_tag,
   output logic [1:0]            pout_kind,
   output logic [SLOT_W-1:0]     pout_slot,
   output logic [DELAY_BITS-1:0] pout_delta,
   output logic [TAG_W-1:0]      pout_tag,
   output logic                  match
);

   localparam int HW = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

   logic                  v_ff, v_in;
   logic [SLOT_W-1:0]     s_ff, s_in;
   logic [DELAY_BITS-1:0] d_ff, d_in;
   logic [TAG_W-1:0]      t_ff, t_in;
   logic [1:0]            pk_ff, pk_in;
   logic [SLOT_W-1:0]     ps_ff, ps_in;
   logic [DELAY_BITS-1:0] pd_ff, pd_in;
   logic [TAG_W-1:0]      pt_ff, pt_in;

   assign match = v_ff && (HW'(s_ff) == HW'(ctl.target));

   always_comb begin
      v_in  = v_ff;
      s_in  = s_ff;
      d_in  = d_ff;
      t_in  = t_ff;
      pk_in = PKT_NONE;
      ps_in = ps_ff;
      pd_in = pd_ff;
      pt_in = pt_ff;
      if (ctl.shift_all) begin
         v_in = nxt_valid;
         s_in = nxt_slot;
         d_in = nxt_delta;
         t_in = nxt_tag;
      end else if (ctl.cancel && match) begin
         if (nxt_valid) begin
            s_in  = nxt_slot;
            d_in  = nxt_delta + d_ff;
            t_in  = nxt_tag;
            pk_in = PKT_HOLE;
         end else begin
            v_in = 1'b0;
         end
      end else if (dec_head) begin
         d_in = d_ff - DELAY_BITS'(1);
      end else begin
         case (pin_kind)
            PKT_HOLE: begin
               if (nxt_valid) begin
                  s_in  = nxt_slot;
                  d_in  = nxt_delta;
                  t_in  = nxt_tag;
                  pk_in = PKT_HOLE;
               end else begin
                  v_in = 1'b0;
               end
            end
            PKT_SEARCH: begin
               if (!v_ff || (pin_delta < d_ff)) begin
                  v_in = 1'b1;
                  s_in = pin_slot;
                  d_in = pin_delta;
                  t_in = pin_tag;
                  if (v_ff) begin
                     pk_in = PKT_PUSH;
                     ps_in = s_ff;
                     pd_in = d_ff - pin_delta;
                     pt_in = t_ff;
                  end
               end else begin
                  pk_in = PKT_SEARCH;
                  ps_in = pin_slot;
                  pd_in = pin_delta - d_ff;
                  pt_in = pin_tag;
               end
            end
            PKT_PUSH: begin
               v_in = 1'b1;
               s_in = pin_slot;
               d_in = pin_delta;
               t_in = pin_tag;
               if (v_ff) begin
                  pk_in = PKT_PUSH;
                  ps_in = s_ff;
                  pd_in = d_ff;
                  pt_in = t_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         pk_ff <= PKT_NONE;
      end else begin
         v_ff  <= v_in;
         pk_ff <= pk_in;
      end
      s_ff  <= s_in;
      d_ff  <= d_in;
      t_ff  <= t_in;
      ps_ff <= ps_in;
      pd_ff <= pd_in;
      pt_ff <= pt_in;
   end

   assign e_valid    = v_ff;
   assign e_slot     = s_ff;
   assign e_delta    = d_ff;
   assign e_tag      = t_ff;
   assign pout_kind  = pk_ff;
   assign pout_slot  = ps_ff;
   assign pout_delta = pd_ff;
   assign pout_tag   = pt_ff;

endmodule

/* hdl/dqte_alloc.sv */
// Slot occupancy bits and lowest free slot search
module dqte_alloc
   import dqte_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int SLOT_W     = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              set_en,
   input  logic [SLOT_W-1:0] set_slot,
   input  logic              clr_en,
   input  logic [SLOT_W-1:0] clr_slot,
   output logic              free_found,
   output logic [SLOT_W-1:0] free_slot
);

   logic [SLOT_COUNT-1:0] act_ff, act_in;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      act_in = act_ff;
      if (set_en) begin
         act_in[set_slot] = 1'b1;
      end
      if (clr_en) begin
         act_in[clr_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= '0;
      end else begin
         act_ff <= act_in;
      end
   end

endmodule

/* hdl/delta_queue_timer_engine_unit.sv */
// Delta queue timer engine: top level with sequencer and chain of list cells
//
// Use: drive req_item and raise start; the item is taken at an edge where
// busy is low. Requests are insert, cancel and tick. Results appear on
// rsp_item for one cycle each, marked by rsp_strobe; the receiver cannot
// stall, so every strobed item must be taken as it comes.
// Insert and cancel reply in the cycle after the item is taken. An insert that
// finds a free slot then keeps busy high while the new entry walks down the
// cell chain, one cell a cycle, and pushes later entries back. A cancel that
// hits keeps busy high while the gap closes. When a tick brings the head to
// zero it is followed by a run of up to MAX_RUN expiries, one a cycle, the
// last flagged by last_of_run, with busy high until the run ends.
// Reset empties the queue and frees every slot; the block is ready at once.
module delta_queue_timer_engine_unit
   import dqte_pkg::*;
#(
   parameter int SLOT_COUNT = SLOT_COUNT_DEF,
   parameter int DELAY_BITS = DELAY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dqte_req_type req_item,
   output logic         rsp_strobe,
   output dqte_rsp_type rsp_item
);

`include "delta_queue_timer_engine_unit_assert.svh"

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_EXPIRE = 2'd2;

   logic [1:0]            st_ff, st_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [1:0]            inj_kind_ff, inj_kind_in;
   logic [SLOT_W-1:0]     inj_slot_ff, inj_slot_in;
   logic [DELAY_BITS-1:0] inj_delta_ff, inj_delta_in;
   logic [TAG_W-1:0]      inj_tag_ff, inj_tag_in;
   dqte_rsp_type          rsp_ff, rsp_in;
   logic                  strobe_ff, strobe_in;

   logic                  req_accept;
   dqte_ctl_type          ctl;
   logic                  dec_head;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_slot;
   logic                  set_en, clr_en;
   logic [SLOT_W-1:0]     clr_slot;
   logic [DELAY_BITS-1:0] dmask, dnorm;
   logic                  hit;
   logic [TAG_W-1:0]      hit_tag;
   logic                  any_pkt;
   logic                  run_last;

   logic [SLOT_COUNT-1:0] e_valid;
   logic [SLOT_W-1:0]     e_slot  [SLOT_COUNT];
   logic [DELAY_BITS-1:0] e_delta [SLOT_COUNT];
   logic [TAG_W-1:0]      e_tag   [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] e_match;
   logic [1:0]            p_kind  [SLOT_COUNT+1];
   logic [SLOT_W-1:0]     p_slot  [SLOT_COUNT+1];
   logic [DELAY_BITS-1:0] p_delta [SLOT_COUNT+1];
   logic [TAG_W-1:0]      p_tag   [SLOT_COUNT+1];

   assign busy       = (st_ff != ST_IDLE);
   assign req_accept = start && !busy;

   assign p_kind[0]  = inj_kind_ff;
   assign p_slot[0]  = inj_slot_ff;
   assign p_delta[0] = inj_delta_ff;
   assign p_tag[0]   = inj_tag_ff;

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      logic                  nv;
      logic [SLOT_W-1:0]     ns;
      logic [DELAY_BITS-1:0] nd;
      logic [TAG_W-1:0]      nt;
      logic                  dh;
      if (i == SLOT_COUNT - 1) begin : g_last
         assign nv = 1'b0;
         assign ns = '0;
         assign nd = '0;
         assign nt = '0;
      end else begin : g_mid
         assign nv = e_valid[i+1];
         assign ns = e_slot[i+1];
         assign nd = e_delta[i+1];
         assign nt = e_tag[i+1];
      end
      if (i == 0) begin : g_head
         assign dh = dec_head;
      end else begin : g_tail
         assign dh = 1'b0;
      end
      dqte_cell #(
         .SLOT_W     (SLOT_W),
         .DELAY_BITS (DELAY_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .dec_head   (dh),
         .pin_kind   (p_kind[i]),
         .pin_slot   (p_slot[i]),
         .pin_delta  (p_delta[i]),
         .pin_tag    (p_tag[i]),
         .nxt_valid  (nv),
         .nxt_slot   (ns),
         .nxt_delta  (nd),
         .nxt_tag    (nt),
         .e_valid    (e_valid[i]),
         .e_slot     (e_slot[i]),
         .e_delta    (e_delta[i]),
         .e_tag      (e_tag[i]),
         .pout_kind  (p_kind[i+1]),
         .pout_slot  (p_slot[i+1]),
         .pout_delta (p_delta[i+1]),
         .pout_tag   (p_tag[i+1]),
         .match      (e_match[i])
      );
   end

   dqte_alloc #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_W     (SLOT_W)
   ) u_alloc (
      .clock      (clock),
      .reset      (reset),
      .set_en     (set_en),
      .set_slot   (free_slot),
      .clr_en     (clr_en),
      .clr_slot   (clr_slot),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   always_comb begin
      hit     = 1'b0;
      hit_tag = '0;
      any_pkt = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit     = hit | e_match[i];
         hit_tag = hit_tag | (e_match[i] ? e_tag[i] : '0);
      end
      for (int i = 0; i <= SLOT_COUNT; i++) begin
         any_pkt = any_pkt | (p_kind[i] != PKT_NONE);
      end
   end

   assign dmask = DELAY_BITS'(req_item.delay_ticks);
   assign dnorm = (dmask == '0) ? DELAY_BITS'(1) : dmask;

   assign run_last = (run_ff == RUN_W'(MAX_RUN - 1)) ||
                     !(e_valid[1] && (e_delta[1] == '0));

   always_comb begin
      st_in         = st_ff;
      run_in        = run_ff;
      inj_kind_in   = PKT_NONE;
      inj_slot_in   = inj_slot_ff;
      inj_delta_in  = inj_delta_ff;
      inj_tag_in    = inj_tag_ff;
      rsp_in        = rsp_ff;
      strobe_in     = 1'b0;
      ctl.shift_all = 1'b0;
      ctl.cancel    = req_accept && (req_item.req_type == REQ_CANCEL);
      ctl.target    = req_item.target_slot;
      dec_head      = 1'b0;
      set_en        = 1'b0;
      clr_en        = 1'b0;
      clr_slot      = SLOT_W'(req_item.target_slot);
      unique case (st_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_item.req_type)
                  REQ_INSERT: begin
                     strobe_in = 1'b1;
                     if (free_found) begin
                        set_en       = 1'b1;
                        inj_kind_in  = PKT_SEARCH;
                        inj_slot_in  = free_slot;
                        inj_delta_in = dnorm;
                        inj_tag_in   = req_item.user_tag;
                        rsp_in       = '{KIND_INSERT, SLOT_FIELD_W'(free_slot),
                                         req_item.user_tag, STAT_OK, 1'b1};
                        st_in        = ST_WALK;
                     end else begin
                        rsp_in = '{KIND_INSERT, '0, '0, STAT_FULL, 1'b1};
                     end
                  end
                  REQ_CANCEL: begin
                     strobe_in = 1'b1;
                     if (hit) begin
                        clr_en = 1'b1;
                        rsp_in = '{KIND_CANCEL, req_item.target_slot, hit_tag,
                                   STAT_OK, 1'b1};
                        st_in  = ST_WALK;
                     end else begin
                        rsp_in = '{KIND_CANCEL, req_item.target_slot, '0,
                                   STAT_NOTACT, 1'b1};
                     end
                  end
                  REQ_TICK: begin
                     if (e_valid[0]) begin
                        dec_head = (e_delta[0] != '0);
                        if ((e_delta[0] == '0) || (e_delta[0] == DELAY_BITS'(1))) begin
                           run_in = '0;
                           st_in  = ST_EXPIRE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!any_pkt) begin
               st_in = ST_IDLE;
            end
         end
         ST_EXPIRE: begin
            ctl.shift_all = 1'b1;
            clr_en        = 1'b1;
            clr_slot      = e_slot[0];
            strobe_in     = 1'b1;
            rsp_in        = '{KIND_EXPIRY, SLOT_FIELD_W'(e_slot[0]), e_tag[0],
                              STAT_OK, run_last};
            run_in        = run_ff + RUN_W'(1);
            if (run_last) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         inj_kind_ff <= PKT_NONE;
         strobe_ff   <= 1'b0;
      end else begin
         st_ff       <= st_in;
         inj_kind_ff <= inj_kind_in;
         strobe_ff   <= strobe_in;
      end
      run_ff       <= run_in;
      inj_slot_ff  <= inj_slot_in;
      inj_delta_ff <= inj_delta_in;
      inj_tag_ff   <= inj_tag_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `DQTE_ASSERT_NEXT(a_reply_next,
      req_accept && (req_item.req_type == REQ_INSERT || req_item.req_type == REQ_CANCEL),
      rsp_strobe, "insert or cancel item gave no reply")
   `DQTE_ASSERT_NOW(a_idle_quiet, !busy, !any_pkt, "packet in flight while idle")
   `DQTE_ASSERT_NOW(a_expire_head, st_ff == ST_EXPIRE,
      e_valid[0] && (e_delta[0] == '0), "expiry without a due head")

endmodule
